// ===== rtl/utf8_stream_decoder_top_defines.svh =====
// Assertion macros shared by the UTF-8 stream decoder RTL.
// Depends on nothing; expects i_clk and i_rst_n in the including module.
`ifndef UTF8_STREAM_DECODER_TOP_DEFINES_SVH
`define UTF8_STREAM_DECODER_TOP_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define UTF8SD_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("utf8sd same-cycle check failed");

// Next-cycle implication, checked out of reset.
`define UTF8SD_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("utf8sd next-cycle check failed");

`endif

// ===== rtl/utf8sd_pkg.sv =====
// Types, constants and the lead-byte decode function of the UTF-8 stream decoder.
// Used by utf8sd_decode, utf8sd_emit and utf8_stream_decoder_top; depends on nothing.
`default_nettype none

package utf8sd_pkg;

    localparam int unsigned CP_W = 21;

    localparam logic        ACT_EOS    = 1'b1;
    localparam logic [CP_W-1:0] QMARK  = 21'h00003F;
    localparam logic [7:0]  ASCII_LIMIT = 8'h80;
    localparam logic [7:0]  LEAD_MIN   = 8'hC2;
    localparam logic [7:0]  LEAD_LIMIT = 8'hF5;
    localparam logic [7:0]  LEAD3_MIN  = 8'hE0;
    localparam logic [7:0]  LEAD4_MIN  = 8'hF0;
    localparam logic [7:0]  LEAD_E0    = 8'hE0;
    localparam logic [7:0]  LEAD_F0    = 8'hF0;
    localparam logic [7:0]  LEAD_F4    = 8'hF4;
    localparam logic [7:0]  CONT2_E0_MIN = 8'hA0;
    localparam logic [7:0]  CONT2_F_SPLIT = 8'h90;

    // Open-sequence state.
    typedef struct packed {
        logic [1:0]      needed;
        logic [1:0]      taken;
        logic [7:0]      lead;
        logic [CP_W-1:0] partial;
    } t_dec_state;

    // Results of one request: rep_cnt replacements, then an optional tail.
    typedef struct packed {
        logic [1:0]      rep_cnt;
        logic            tail_v;
        logic [CP_W-1:0] tail_cp;
        logic            tail_rep;
        logic            tail_eos;
    } t_batch;

    // One result item on the output side.
    typedef struct packed {
        logic [CP_W-1:0] cp;
        logic            rep;
        logic            eos;
        logic            last;
    } t_result;

    typedef struct packed {
        t_dec_state      st;
        logic            res_v;
        logic [CP_W-1:0] cp;
        logic            rep;
    } t_lead;

    // Decode a byte as a lead byte from the idle state.
    function automatic t_lead take_lead(input logic [7:0] b);
        t_lead r;
        r = '0;
        if (b < ASCII_LIMIT) begin
            r.res_v = 1'b1;
            r.cp    = {13'd0, b};
        end else if (b < LEAD_MIN || b >= LEAD_LIMIT) begin
            r.res_v = 1'b1;
            r.cp    = QMARK;
            r.rep   = 1'b1;
        end else begin
            r.st.lead = b;
            if (b < LEAD3_MIN) begin
                r.st.needed  = 2'd1;
                r.st.partial = {16'd0, b[4:0]};
            end else if (b < LEAD4_MIN) begin
                r.st.needed  = 2'd2;
                r.st.partial = {17'd0, b[3:0]};
            end else begin
                r.st.needed  = 2'd3;
                r.st.partial = {18'd0, b[2:0]};
            end
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/utf8sd_decode.sv =====
// Sequence state and single-pass decode of one request into a result batch.
// Depends on utf8sd_pkg.
`default_nettype none

module utf8sd_decode (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_load,
    input  wire logic              i_action,
    input  wire logic [7:0]        i_byte,
    output utf8sd_pkg::t_batch     o_batch
);

    utf8sd_pkg::t_dec_state r_state;
    utf8sd_pkg::t_dec_state n_state;
    utf8sd_pkg::t_lead      w_lead;
    logic                   w_ok;
    logic [utf8sd_pkg::CP_W-1:0] w_shifted;

    always_comb begin
        n_state   = r_state;
        o_batch   = '0;
        w_lead    = utf8sd_pkg::take_lead(i_byte);
        w_shifted = {r_state.partial[utf8sd_pkg::CP_W-7:0], i_byte[5:0]};
        w_ok      = (i_byte[7:6] == 2'b10);
        if (r_state.taken == 2'd0) begin
            if (r_state.lead == utf8sd_pkg::LEAD_E0 && i_byte < utf8sd_pkg::CONT2_E0_MIN)
                w_ok = 1'b0;
            if (r_state.lead == utf8sd_pkg::LEAD_F0 && i_byte < utf8sd_pkg::CONT2_F_SPLIT)
                w_ok = 1'b0;
            if (r_state.lead == utf8sd_pkg::LEAD_F4 && i_byte >= utf8sd_pkg::CONT2_F_SPLIT)
                w_ok = 1'b0;
        end

        if (i_action == utf8sd_pkg::ACT_EOS) begin
            // drop any open sequence, emit the end marker
            n_state          = '0;
            o_batch.tail_v   = 1'b1;
            o_batch.tail_eos = 1'b1;
        end else if (r_state.needed == 2'd0) begin
            n_state          = w_lead.st;
            o_batch.tail_v   = w_lead.res_v;
            o_batch.tail_cp  = w_lead.cp;
            o_batch.tail_rep = w_lead.rep;
        end else if (w_ok) begin
            n_state.partial = w_shifted;
            n_state.taken   = r_state.taken + 2'd1;
            n_state.needed  = r_state.needed - 2'd1;
            if (r_state.needed == 2'd1) begin
                n_state         = '0;
                o_batch.tail_v  = 1'b1;
                o_batch.tail_cp = w_shifted;
            end
        end else begin
            // replace lead and taken bytes, then retry the breaking byte as a lead
            o_batch.rep_cnt  = (r_state.taken == 2'd3) ? 2'd3 : r_state.taken + 2'd1;
            n_state          = w_lead.st;
            o_batch.tail_v   = w_lead.res_v;
            o_batch.tail_cp  = w_lead.cp;
            o_batch.tail_rep = w_lead.rep;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '0;
        end else if (i_load) begin
            r_state <= n_state;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/utf8sd_emit.sv =====
// Result register that plays out one batch as a run of result items.
// Depends on utf8sd_pkg.
`default_nettype none

module utf8sd_emit (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_load,
    input  wire utf8sd_pkg::t_batch i_batch,
    input  wire logic               i_ready,
    output logic                    o_valid,
    output logic                    o_free,
    output utf8sd_pkg::t_result     o_result
);

    logic [1:0]                  r_cnt;
    logic                        r_tail_v;
    logic [utf8sd_pkg::CP_W-1:0] r_tail_cp;
    logic                        r_tail_rep;
    logic                        r_tail_eos;
    logic                        w_fire;

    always_comb begin
        o_valid = (r_cnt != 2'd0) || r_tail_v;
        if (r_cnt != 2'd0) begin
            o_result.cp   = utf8sd_pkg::QMARK;
            o_result.rep  = 1'b1;
            o_result.eos  = 1'b0;
            o_result.last = (r_cnt == 2'd1) && !r_tail_v;
        end else begin
            o_result.cp   = r_tail_cp;
            o_result.rep  = r_tail_rep;
            o_result.eos  = r_tail_eos;
            o_result.last = 1'b1;
        end
        w_fire = o_valid && i_ready;
        o_free = !o_valid || (w_fire && o_result.last);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt    <= 2'd0;
            r_tail_v <= 1'b0;
        end else if (i_load) begin
            r_cnt    <= i_batch.rep_cnt;
            r_tail_v <= i_batch.tail_v;
        end else if (w_fire) begin
            if (r_cnt != 2'd0) begin
                r_cnt <= r_cnt - 2'd1;
            end else begin
                r_tail_v <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_tail_cp  <= i_batch.tail_cp;
            r_tail_rep <= i_batch.tail_rep;
            r_tail_eos <= i_batch.tail_eos;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/utf8_stream_decoder_top.sv =====
// UTF-8 stream decoder: bytes in, Unicode code points out, '?' for invalid bytes.
// A request passes the input register, then the result register, on its way to the output.
// Throughput: one request per cycle while each makes at most one result and the
// output does not stall; a broken sequence stalls the input for its extra results (up to 3).
// Reset: synchronous, active low; clears the input register, sequence state and results.
// Depends on utf8sd_pkg, utf8sd_decode, utf8sd_emit and utf8_stream_decoder_top_defines.svh.
`default_nettype none
`include "utf8_stream_decoder_top_defines.svh"

module utf8_stream_decoder_top (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // input request stream
    input  wire logic        i_s_axis_tvalid,
    output logic             o_s_axis_tready,
    input  wire logic [7:0]  i_s_axis_tdata,   // [7:0] data_byte
    input  wire logic        i_s_axis_tuser,   // [0] action (1 = end of stream)
    // output result stream
    output logic             o_m_axis_tvalid,
    input  wire logic        i_m_axis_tready,
    output logic [23:0]      o_m_axis_tdata,   // [20:0] code_point, [23:21] zero
    output logic [1:0]       o_m_axis_tuser,   // [0] is_replacement, [1] end_of_stream
    output logic             o_m_axis_tlast    // last result of this request
);

    // Input register: one request waiting for the decode stage.
    logic       r_in_v;
    logic       r_in_action;
    logic [7:0] r_in_byte;

    logic                w_free;
    logic                w_load;
    logic                w_in_fire;
    utf8sd_pkg::t_batch  w_batch;
    utf8sd_pkg::t_result w_result;

    // Decode the held request when the result register empties this cycle.
    assign w_load          = r_in_v && w_free;
    assign o_s_axis_tready = !r_in_v || w_load;
    assign w_in_fire       = i_s_axis_tvalid && o_s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_v <= 1'b0;
        end else if (w_in_fire) begin
            r_in_v <= 1'b1;
        end else if (w_load) begin
            r_in_v <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_fire) begin
            r_in_action <= i_s_axis_tuser;
            r_in_byte   <= i_s_axis_tdata;
        end
    end

    // Sequence state lives here; advance it as the request moves on.
    utf8sd_decode u_decode (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (w_load),
        .i_action (r_in_action),
        .i_byte   (r_in_byte),
        .o_batch  (w_batch)
    );

    // Hold the batch; play replacements, then tail, one per cycle while output is ready.
    utf8sd_emit u_emit (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (w_load),
        .i_batch  (w_batch),
        .i_ready  (i_m_axis_tready),
        .o_valid  (o_m_axis_tvalid),
        .o_free   (w_free),
        .o_result (w_result)
    );

    assign o_m_axis_tdata = {3'd0, w_result.cp};
    assign o_m_axis_tuser = {w_result.eos, w_result.rep};
    assign o_m_axis_tlast = w_result.last;

    // End marker is a lone zero result that closes its request.
    `UTF8SD_ASSERT_NOW(a_eos_shape, o_m_axis_tvalid && o_m_axis_tuser[1],
        o_m_axis_tlast && !o_m_axis_tuser[0] && o_m_axis_tdata == 24'd0)
    // Every replacement carries '?'.
    `UTF8SD_ASSERT_NOW(a_rep_is_qmark, o_m_axis_tvalid && o_m_axis_tuser[0],
        o_m_axis_tdata == 24'h00003F && !o_m_axis_tuser[1])
    // Input stalls only while a request waits behind a busy result register.
    `UTF8SD_ASSERT_NOW(a_stall_cause, !o_s_axis_tready, r_in_v && !w_free)
    // A loaded request frees the input register unless a new one came in.
    `UTF8SD_ASSERT_NEXT(a_load_drains, w_load && !w_in_fire, !r_in_v)

endmodule

`default_nettype wire
